@@ rtl/deqs_pkg.sv @@
// Shared types and codes for the searchable double-ended queue.
`default_nettype none
package deqs_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CONTAINS   = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 7;

  typedef struct packed {
    logic [2:0]                   command;
    logic signed [ValueWidth-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic                         found;
    logic signed [ValueWidth-1:0] front_value;
    logic signed [ValueWidth-1:0] back_value;
    logic [CountWidth-1:0]        count;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/deqs_store.sv @@
// Entry memory: one write port, two read ports with registered read data.
`default_nettype none
module deqs_store
  import deqs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [ValueWidth-1:0]   wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [ValueWidth-1:0]   rdata_a_o,
  output logic      [ValueWidth-1:0]   rdata_b_o
);

  logic [ValueWidth-1:0] mem_q [DEPTH];
  logic [ValueWidth-1:0] rdata_a_q;
  logic [ValueWidth-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

@@ rtl/deqs_slot_add.sv @@
// Shared slot adder: (base + offset) modulo DEPTH with one compare and subtract.
`default_nettype none
module deqs_slot_add #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic [$clog2(DEPTH)-1:0]   base_i,
  input  wire logic [$clog2(DEPTH+1)-1:0] offset_i,
  output logic      [$clog2(DEPTH)-1:0]   slot_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  always_comb begin
    sum     = SW'(base_i) + SW'(offset_i);
    wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    slot_o  = wrapped[AW-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/double_ended_queue_with_search.sv @@
// Top level: bounded deque with value search and ordered removal.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one command
//   per beat: push front, push back, pop front, pop back, contains, remove.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns one beat
//   per command: status, found flag, front and back values, entry count.
//   A beat moves on a rising edge with valid high and stall low.
//
// Sequencing:
//   One command at a time; in_stall_o is high until the result is loaded
//   into the output register. Push and pop pass through the execute, fetch,
//   wait and done states. Contains and remove read the stored entries in
//   turn and stop at the first match; a remove that matches then moves
//   the entries behind it up one slot per cycle. A single slot adder and a
//   single memory read port walk the entries, one per cycle.
//
// Reset clears the count and the front slot; the memory is not cleared.
// A stalled result holds in the output register; the next command is
// accepted meanwhile and waits in its final state until the register frees.
`default_nettype none
module double_ended_queue_with_search
  import deqs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FETCH,
    S_WAIT,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [2:0]            cmd_q;
  logic [ValueWidth-1:0] val_q;
  logic [AW-1:0]         front_q;
  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         k_q;          // offset of the next read to issue
  logic                  rd_v_q;       // read data valid for the last issued read
  logic [AW-1:0]         prev_addr_q;  // slot of the last issued read
  logic [AW-1:0]         wtgt_q;       // slot to fill during the shift
  logic [1:0]            status_q;
  logic                  found_q;
  out_item_t             res_q;
  out_item_t             out_q;
  logic                  out_valid_q;

  // Shared slot adder and memory hookup.
  logic [CW-1:0]         offset;
  logic [AW-1:0]         slot;
  logic [AW-1:0]         raddr_a;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ValueWidth-1:0] rdata_a;
  logic [ValueWidth-1:0] rdata_b;

  logic                  full;
  logic                  empty;
  logic                  issue;
  logic                  match;
  logic [CW+6:0]         cnt_wide;

  assign full  = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);
  assign issue = (k_q < cnt_q);
  assign match = rd_v_q && (rdata_a == val_q);

  deqs_slot_add #(
    .DEPTH (DEPTH)
  ) u_slot_add (
    .base_i   (front_q),
    .offset_i (offset),
    .slot_o   (slot)
  );

  deqs_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   ((state_q == S_SHIFT) ? rdata_a : val_q),
    .raddr_a_i (raddr_a),
    .raddr_b_i (slot),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Select the adder offset, read and write addresses per state.
  always_comb begin
    offset    = k_q;
    raddr_a   = slot;
    mem_we    = 1'b0;
    mem_waddr = slot;
    unique case (state_q)
      S_EXEC: begin
        case (cmd_q)
          CMD_PUSH_FRONT: begin
            offset = CW'(DEPTH - 1);
            mem_we = !full;
          end
          CMD_PUSH_BACK: begin
            offset = cnt_q;
            mem_we = !full;
          end
          CMD_POP_FRONT: offset = CW'(1);
          default:       offset = '0;
        endcase
      end
      S_SCAN, S_SHIFT: begin
        offset    = k_q;
        mem_we    = (state_q == S_SHIFT) && rd_v_q;
        mem_waddr = wtgt_q;
      end
      S_FETCH: begin
        offset  = empty ? '0 : (cnt_q - CW'(1));
        raddr_a = front_q;
      end
      default: offset = k_q;
    endcase
  end

  assign cnt_wide = {{7{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      val_q       <= '0;
      front_q     <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      prev_addr_q <= '0;
      wtgt_q      <= '0;
      status_q    <= STATUS_OK;
      found_q     <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result once the receiver takes it, unless a new one loads.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= in_item_i.command;
            val_q    <= in_item_i.value;
            status_q <= STATUS_OK;
            found_q  <= 1'b0;
            state_q  <= S_EXEC;
          end
        end

        S_EXEC: begin
          k_q    <= '0;
          rd_v_q <= 1'b0;
          state_q <= S_FETCH;
          case (cmd_q)
            CMD_PUSH_FRONT: begin
              if (full) begin
                status_q <= STATUS_FULL;
              end else begin
                front_q <= slot;
                cnt_q   <= cnt_q + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                status_q <= STATUS_FULL;
              end else begin
                cnt_q <= cnt_q + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                status_q <= STATUS_EMPTY;
              end else begin
                front_q <= slot;
                cnt_q   <= cnt_q - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                status_q <= STATUS_EMPTY;
              end else begin
                cnt_q <= cnt_q - CW'(1);
              end
            end
            CMD_CONTAINS: state_q <= S_SCAN;
            CMD_REMOVE: begin
              if (empty) begin
                status_q <= STATUS_EMPTY;
              end else begin
                state_q <= S_SCAN;
              end
            end
            default: state_q <= S_FETCH;
          endcase
        end

        // Issue one read per cycle, compare the previous read's data.
        S_SCAN: begin
          if (match) begin
            found_q <= 1'b1;
            rd_v_q  <= 1'b0;
            wtgt_q  <= prev_addr_q;
            state_q <= (cmd_q == CMD_REMOVE) ? S_SHIFT : S_FETCH;
          end else if (issue) begin
            prev_addr_q <= slot;
            k_q         <= k_q + CW'(1);
            rd_v_q      <= 1'b1;
          end else begin
            rd_v_q  <= 1'b0;
            state_q <= S_FETCH;
          end
        end

        // Move each later entry up one slot to close the gap.
        S_SHIFT: begin
          rd_v_q <= issue;
          if (issue) begin
            prev_addr_q <= slot;
            k_q         <= k_q + CW'(1);
          end
          if (rd_v_q) begin
            wtgt_q <= prev_addr_q;
          end
          if (!issue && !rd_v_q) begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_FETCH;
          end
        end

        S_FETCH: state_q <= S_WAIT;

        S_WAIT: begin
          res_q.status      <= status_q;
          res_q.found       <= found_q;
          res_q.front_value <= empty ? '0 : rdata_a;
          res_q.back_value  <= empty ? '0 : rdata_b;
          res_q.count       <= cnt_wide[6:0];
          state_q           <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.count == '0) |-> (out_q.front_value == '0 &&
      out_q.back_value == '0))
    else $error("empty result carries nonzero end values");

  a_shift_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cmd_q == CMD_REMOVE && found_q))
    else $error("shift without a matched remove");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_EXEC || state_q == S_SHIFT))
    else $error("memory write outside push or shift");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted command not executed");
`endif

endmodule
`default_nettype wire
